@@ sv/printer_escape_command_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// printer_escape_command_decoder_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PRINTER_ESCAPE_COMMAND_DECODER_ASSERT_SVH
`define PRINTER_ESCAPE_COMMAND_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PECD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PECD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pecd_pkg.sv @@
// ----------------------------------------------------------------------------
// pecd_pkg
// types, byte codes and the national character table of the escape decoder
// ----------------------------------------------------------------------------
package pecd_pkg;

  // action reported with each item
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_PRINT = 3'd1,
    ACT_CR    = 3'd2,
    ACT_LF    = 3'd3,
    ACT_FF    = 3'd4,
    ACT_BS    = 3'd5
  } action_e;

  // pitch and script codes
  localparam logic [1:0] PITCH_PICA       = 2'd0;
  localparam logic [1:0] PITCH_ELITE      = 2'd1;
  localparam logic [1:0] PITCH_COMPRESSED = 2'd2;
  localparam logic [1:0] SCRIPT_NORMAL    = 2'd0;
  localparam logic [1:0] SCRIPT_SUPER     = 2'd1;
  localparam logic [1:0] SCRIPT_SUB       = 2'd2;

  // control bytes
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SO  = 8'h0E;
  localparam logic [7:0] CH_SI  = 8'h0F;
  localparam logic [7:0] CH_DC1 = 8'h11;
  localparam logic [7:0] CH_DC2 = 8'h12;
  localparam logic [7:0] CH_DC3 = 8'h13;
  localparam logic [7:0] CH_DC4 = 8'h14;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_ESC = 8'h1B;

  // escape command bytes
  localparam logic [7:0] CMD_NONE        = 8'h00;
  localparam logic [7:0] CMD_RESET       = 8'h40;
  localparam logic [7:0] CMD_CR          = 8'h3C;
  localparam logic [7:0] CMD_ITALIC_ON   = 8'h34;
  localparam logic [7:0] CMD_ITALIC_OFF  = 8'h35;
  localparam logic [7:0] CMD_EMPH_ON     = 8'h45;
  localparam logic [7:0] CMD_EMPH_OFF    = 8'h46;
  localparam logic [7:0] CMD_DSTRIKE_ON  = 8'h47;
  localparam logic [7:0] CMD_DSTRIKE_OFF = 8'h48;
  localparam logic [7:0] CMD_ELITE_ON    = 8'h4D;
  localparam logic [7:0] CMD_ELITE_OFF   = 8'h50;
  localparam logic [7:0] CMD_SCRIPT_OFF  = 8'h54;
  localparam logic [7:0] CMD_UNDERLINE   = 8'h2D;
  localparam logic [7:0] CMD_MASTER      = 8'h21;
  localparam logic [7:0] CMD_CHARSET     = 8'h52;
  localparam logic [7:0] CMD_SCRIPT      = 8'h53;
  localparam logic [7:0] CMD_UNIDIR      = 8'h55;
  localparam logic [7:0] CMD_EXPANDED    = 8'h57;
  localparam logic [7:0] CMD_PROP        = 8'h70;
  localparam logic [7:0] CMD_SPEED       = 8'h73;
  localparam logic [7:0] CMD_IMMEDIATE   = 8'h69;

  // parameter values
  localparam logic [7:0] PARAM_ZERO = 8'h30;
  localparam logic [7:0] PARAM_ONE  = 8'h31;

  // national sets
  localparam int unsigned NUM_SETS      = 9;
  localparam int unsigned NUM_NAT_CODES = 12;
  localparam logic [3:0]  SET_USA       = 4'd0;
  localparam logic [3:0]  SET_LAST      = 4'd8;
  localparam logic [7:0]  ITALIC_BIT    = 8'h80;

  // row 0 is the usa set and doubles as the lookup key
  localparam logic [7:0] NAT_MAP [NUM_SETS][NUM_NAT_CODES] = '{
    '{8'd35, 8'd36, 8'd64, 8'd91, 8'd92, 8'd93, 8'd94, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126},
    '{8'd35, 8'd36, 8'd0,  8'd5,  8'd15, 8'd16, 8'd94, 8'd96, 8'd30,  8'd2,   8'd1,   8'd22},
    '{8'd35, 8'd36, 8'd16, 8'd23, 8'd24, 8'd25, 8'd94, 8'd96, 8'd26,  8'd27,  8'd28,  8'd17},
    '{8'd6,  8'd36, 8'd64, 8'd91, 8'd92, 8'd93, 8'd94, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126},
    '{8'd35, 8'd36, 8'd64, 8'd18, 8'd20, 8'd13, 8'd94, 8'd96, 8'd19,  8'd21,  8'd14,  8'd126},
    '{8'd35, 8'd11, 8'd29, 8'd23, 8'd24, 8'd13, 8'd25, 8'd30, 8'd26,  8'd27,  8'd14,  8'd28},
    '{8'd35, 8'd36, 8'd64, 8'd5,  8'd92, 8'd30, 8'd94, 8'd30, 8'd0,   8'd3,   8'd1,   8'd4},
    '{8'd12, 8'd36, 8'd64, 8'd7,  8'd9,  8'd8,  8'd94, 8'd96, 8'd22,  8'd10,  8'd125, 8'd126},
    '{8'd35, 8'd36, 8'd64, 8'd91, 8'd31, 8'd93, 8'd94, 8'd96, 8'd123, 8'd124, 8'd125, 8'd126}
  };

  // parser and print mode state
  typedef struct packed {
    logic       escape_seen;
    logic [7:0] pending;
    logic       elite;
    logic       compressed;
    logic       expanded;
    logic       one_line;
    logic       emphasized;
    logic       dstrike;
    logic       italic;
    logic       underline;
    logic       superscript;
    logic       subscript;
    logic       proportional;
    logic [3:0] charset;
  } pstate_t;

  localparam pstate_t PSTATE_RESET = '0;

  // one result item
  typedef struct packed {
    action_e    action;
    logic [7:0] char_code;
    logic [1:0] pitch;
    logic       double_width;
    logic       emphasized;
    logic       double_strike;
    logic       underline;
    logic [1:0] script;
    logic       proportional;
  } result_t;

endpackage

@@ sv/pecd_glyph_map.sv @@
// ----------------------------------------------------------------------------
// pecd_glyph_map
// national character substitution and italic bit for a printed byte
// ----------------------------------------------------------------------------
module pecd_glyph_map import pecd_pkg::*; (
  input  logic [7:0] data_byte_i,
  input  logic [3:0] charset_i,
  input  logic       italic_i,
  output logic [7:0] glyph_o
);

  logic [7:0] mapped;
  logic       hit;

  // compare against the usa row, take the selected set's entry on a hit
  always_comb begin
    mapped = data_byte_i;
    hit    = 1'b0;
    if (charset_i != SET_USA && charset_i <= SET_LAST) begin
      for (int k = 0; k < NUM_NAT_CODES; k++) begin
        if (!hit && NAT_MAP[0][k] == data_byte_i) begin
          mapped = NAT_MAP[charset_i][k];
          hit    = 1'b1;
        end
      end
    end
  end

  assign glyph_o = italic_i ? (mapped | ITALIC_BIT) : mapped;

endmodule

@@ sv/pecd_decode.sv @@
// ----------------------------------------------------------------------------
// pecd_decode
// per-byte parser: next mode state and the result item
// ----------------------------------------------------------------------------
module pecd_decode import pecd_pkg::*; (
  input  logic [7:0] data_byte_i,
  input  pstate_t    state_i,
  output pstate_t    state_o,
  output result_t    result_o
);

  logic [7:0] glyph;
  action_e    act;
  pstate_t    ns;

  pecd_glyph_map u_glyph_map (
    .data_byte_i (data_byte_i),
    .charset_i   (state_i.charset),
    .italic_i    (state_i.italic),
    .glyph_o     (glyph)
  );

  // parser next state
  always_comb begin
    ns  = state_i;
    act = ACT_NONE;
    if (state_i.escape_seen) begin
      ns.escape_seen = 1'b0;
      ns.pending     = CMD_NONE;
      case (data_byte_i)
        CMD_RESET: begin
          ns          = PSTATE_RESET;
          ns.one_line = state_i.one_line;
        end
        CMD_CR:          act = ACT_CR;
        CH_SO:           ns.one_line = 1'b1;
        CH_SI:           ns.compressed = 1'b1;
        CMD_ITALIC_ON:   ns.italic = 1'b1;
        CMD_ITALIC_OFF:  ns.italic = 1'b0;
        CMD_EMPH_ON:     ns.emphasized = 1'b1;
        CMD_EMPH_OFF:    ns.emphasized = 1'b0;
        CMD_DSTRIKE_ON:  ns.dstrike = 1'b1;
        CMD_DSTRIKE_OFF: ns.dstrike = 1'b0;
        CMD_ELITE_ON:    ns.elite = 1'b1;
        CMD_ELITE_OFF:   ns.elite = 1'b0;
        CMD_SCRIPT_OFF: begin
          ns.superscript = 1'b0;
          ns.subscript   = 1'b0;
        end
        CMD_UNDERLINE, CMD_MASTER, CMD_CHARSET, CMD_SCRIPT, CMD_UNIDIR,
        CMD_EXPANDED, CMD_PROP, CMD_SPEED, CMD_IMMEDIATE: begin
          ns.pending = data_byte_i;
        end
        // unknown commands just end the sequence
        default: ;
      endcase
    end else if (state_i.pending != CMD_NONE) begin
      ns.pending = CMD_NONE;
      case (state_i.pending)
        CMD_UNDERLINE: begin
          if (data_byte_i == PARAM_ZERO) ns.underline = 1'b0;
          else if (data_byte_i == PARAM_ONE) ns.underline = 1'b1;
        end
        CMD_MASTER: begin
          ns.expanded   = data_byte_i[5];
          ns.dstrike    = data_byte_i[4];
          ns.emphasized = data_byte_i[3];
          ns.compressed = data_byte_i[2];
          ns.elite      = data_byte_i[0];
        end
        CMD_CHARSET: begin
          ns.charset = (data_byte_i > {4'd0, SET_LAST}) ? SET_USA : data_byte_i[3:0];
        end
        CMD_SCRIPT: begin
          if (data_byte_i == PARAM_ZERO) begin
            ns.superscript = 1'b1;
            ns.subscript   = 1'b0;
          end else if (data_byte_i == PARAM_ONE) begin
            ns.superscript = 1'b0;
            ns.subscript   = 1'b1;
          end
        end
        CMD_EXPANDED: begin
          if (data_byte_i == PARAM_ONE) ns.expanded = 1'b1;
          else if (data_byte_i == PARAM_ZERO) ns.expanded = 1'b0;
        end
        CMD_PROP: begin
          if (data_byte_i == PARAM_ONE) ns.proportional = 1'b1;
          else if (data_byte_i == PARAM_ZERO) ns.proportional = 1'b0;
        end
        // parameter discarded
        default: ;
      endcase
    end else begin
      case (data_byte_i)
        CH_BEL, CH_HT, CH_DC1, CH_DC3, CH_CAN: ;
        CH_BS: act = ACT_BS;
        CH_LF: begin
          ns.one_line = 1'b0;
          act         = ACT_LF;
        end
        CH_VT, CH_DC4: ns.one_line = 1'b0;
        CH_FF: begin
          ns.one_line = 1'b0;
          act         = ACT_FF;
        end
        CH_CR: begin
          ns.one_line = 1'b0;
          act         = ACT_CR;
        end
        CH_SO:  ns.one_line = 1'b1;
        CH_SI:  ns.compressed = 1'b1;
        CH_DC2: ns.compressed = 1'b0;
        CH_ESC: ns.escape_seen = 1'b1;
        default: act = ACT_PRINT;
      endcase
    end
  end

  // result fields reflect the state after the byte
  always_comb begin
    result_o.action        = act;
    result_o.char_code     = (act == ACT_PRINT) ? glyph : 8'd0;
    result_o.pitch         = ns.elite ? PITCH_ELITE :
                             (ns.compressed ? PITCH_COMPRESSED : PITCH_PICA);
    result_o.double_width  = ns.expanded | ns.one_line;
    result_o.emphasized    = ns.emphasized;
    result_o.double_strike = ns.dstrike;
    result_o.underline     = ns.underline;
    result_o.script        = ns.superscript ? SCRIPT_SUPER :
                             (ns.subscript ? SCRIPT_SUB : SCRIPT_NORMAL);
    result_o.proportional  = ns.proportional;
  end

  assign state_o = ns;

endmodule

@@ sv/printer_escape_command_decoder.sv @@
// Path: an accepted item is held in the input register, then in the result register that drives the ports.
// Throughput: one item per cycle while out_stall_i is low; the decode between the input
// register and the result register is a single pass of flat logic and a 12-way compare.
// Stalls: a stalled result holds the input register; in_stall_o rises in the same
// cycle once that register is full, so at most one more item is absorbed.
// Reset: rst_ni low clears parser state, mode flags, usa charset and both valid flags.
// ----------------------------------------------------------------------------
// printer_escape_command_decoder
// byte stream parser for printer escape sequences and print mode flags
// ----------------------------------------------------------------------------
module printer_escape_command_decoder import pecd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [7:0] char_code_o,
  output logic [1:0] pitch_o,
  output logic       double_width_o,
  output logic       emphasized_o,
  output logic       double_strike_o,
  output logic       underline_o,
  output logic [1:0] script_o,
  output logic       proportional_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  result_t    result;
  pstate_t    state_q, state_d;
  logic       in_accept;
  logic       advance;

  // handshake: the input register moves on whenever the result slot frees
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  pecd_decode u_decode (
    .data_byte_i (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  // control and mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= PSTATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) in_byte_q <= data_byte_i;
    if (advance) out_q <= result;
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_q.action;
  assign char_code_o     = out_q.char_code;
  assign pitch_o         = out_q.pitch;
  assign double_width_o  = out_q.double_width;
  assign emphasized_o    = out_q.emphasized;
  assign double_strike_o = out_q.double_strike;
  assign underline_o     = out_q.underline;
  assign script_o        = out_q.script;
  assign proportional_o  = out_q.proportional;

endmodule

@@ sv/pecd_checker.sv @@
// ----------------------------------------------------------------------------
// pecd_checker
// port-level checks of the escape decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "printer_escape_command_decoder_assert.svh"

module pecd_checker import pecd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [7:0] char_code_o,
  input logic [1:0] pitch_o,
  input logic       double_width_o,
  input logic       emphasized_o,
  input logic       double_strike_o,
  input logic       underline_o,
  input logic [1:0] script_o,
  input logic       proportional_o
);

  logic        in_fire;
  logic        in_held;
  logic        out_held;
  logic        out_noprint;
  logic [19:0] out_fields;

  // handshake terms and the whole result payload
  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_held     = in_valid_i && in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign out_noprint = out_valid_o && (action_o != ACT_PRINT);
  assign out_fields  = {action_o, char_code_o, pitch_o, double_width_o, emphasized_o,
                        double_strike_o, underline_o, script_o, proportional_o};

  // a stalled result item holds
  `PECD_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_fields), "result moved")

  // a stalled input item holds
  `PECD_ASSERT_NEXT(a_in_hold, in_held, in_valid_i && $stable(data_byte_i), "input moved")

  // only printed items carry a glyph
  `PECD_ASSERT_IMPLY(a_code_zero, out_noprint, char_code_o == 8'd0, "glyph on non-print")

  // pitch and script never take the unused code
  `PECD_ASSERT_IMPLY(a_codes, out_valid_o, pitch_o != 2'd3 && script_o != 2'd3, "bad code")

  // an accepted item is followed by a valid result when the result is not stalled in between
  `PECD_ASSERT_NEXT(a_latency, in_fire ##1 !out_stall_i, out_valid_o, "result item missing")

endmodule

bind printer_escape_command_decoder pecd_checker u_pecd_checker (.*);
